>>> hdl/ptb_pkg.sv
`default_nettype none
package ptb_pkg;

  localparam int unsigned MONEY_W    = 32;
  localparam int unsigned PRICE_W    = 16;
  localparam int unsigned BOUND_W    = 16;
  localparam int unsigned TIER_SCALE = 100;
  // 65535 * 100 fits in 23 bits
  localparam int unsigned LIMIT_W    = 23;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIER_ONE_BOUND  = 3'd0,
    REG_TIER_TWO_BOUND  = 3'd1,
    REG_PRICE_ONE       = 3'd2,
    REG_PRICE_TWO       = 3'd3,
    REG_PRICE_THREE     = 3'd4,
    REG_WARN_MARGIN     = 3'd5,
    REG_OVERDRAFT_LIMIT = 3'd6,
    REG_CYCLE_BASE      = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    CMD_PULSE = 1'b0,
    CMD_LOAD  = 1'b1
  } command_t;

  typedef struct packed {
    logic               counted;
    logic [PRICE_W-1:0] unit_price;
    logic [MONEY_W-1:0] balance;
    logic [MONEY_W-1:0] overdraft;
    logic [MONEY_W-1:0] money_used;
    logic [MONEY_W-1:0] gas_total;
    logic               low_alert;
    logic               close_valve;
  } result_t;

endpackage
`default_nettype wire

>>> hdl/ptb_in_if.sv
`default_nettype none
interface ptb_in_if;
  import ptb_pkg::*;

  logic               valid;
  logic               ready;
  logic               command;
  logic               pin_low;
  logic [MONEY_W-1:0] amount;

  modport source (output valid, output command, output pin_low, output amount, input ready);
  modport sink   (input valid, input command, input pin_low, input amount, output ready);
endinterface
`default_nettype wire

>>> hdl/ptb_out_if.sv
`default_nettype none
interface ptb_out_if;
  import ptb_pkg::*;

  logic               valid;
  logic               ready;
  logic               counted;
  logic [PRICE_W-1:0] unit_price;
  logic [MONEY_W-1:0] balance;
  logic [MONEY_W-1:0] overdraft;
  logic [MONEY_W-1:0] money_used;
  logic [MONEY_W-1:0] gas_total;
  logic               low_alert;
  logic               close_valve;

  modport source (
    output valid, output counted, output unit_price, output balance, output overdraft,
    output money_used, output gas_total, output low_alert, output close_valve,
    input ready
  );
  modport sink (
    input valid, input counted, input unit_price, input balance, input overdraft,
    input money_used, input gas_total, input low_alert, input close_valve,
    output ready
  );
endinterface
`default_nettype wire

>>> hdl/pulse_tariff_billing_core.sv
// Each accepted item's result is written to the output register at the accepting edge.
// Throughput: one item per cycle while results are taken; the billing state updates at the accepting edge,
// so each item sees the state left by the one before it.
// The input is ready whenever the result register is empty or being taken.
// Reset (rst_n low, synchronous): billing state and registers clear, alert re-arms,
// result register empties.
`default_nettype none
module pulse_tariff_billing_core (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  [ptb_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire  [ptb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  ptb_in_if.sink                            in_ch,
  ptb_out_if.source                         out_ch
);
  import ptb_pkg::*;

  // configuration; tier bounds are held already scaled
  logic [LIMIT_W-1:0] t1_lim_r, t2_lim_r;
  logic [PRICE_W-1:0] p1_r, p2_r, p3_r;
  logic [MONEY_W-1:0] warn_r, odl_r, base_r;
  logic [LIMIT_W-1:0] cfg_lim;

  // billing state
  logic [MONEY_W-1:0] gas_r, bal_r, owed_r, spent_r;
  logic [MONEY_W-1:0] gas_nxt, bal_nxt, owed_nxt, spent_nxt;
  logic               armed_r, armed_nxt;

  // result register
  result_t res_r, res_nxt;
  logic    out_valid_r;

  logic               in_acc;
  logic [MONEY_W-1:0] gas_inc, usage, price_ext, bal_sub;
  logic [PRICE_W-1:0] price;
  logic [MONEY_W:0]   owed_sum, cover_sum;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign cfg_lim = LIMIT_W'({{(LIMIT_W-BOUND_W){1'b0}}, cfg_wdata[BOUND_W-1:0]} *
                            LIMIT_W'(TIER_SCALE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_lim_r <= '0;
      t2_lim_r <= '0;
      p1_r     <= '0;
      p2_r     <= '0;
      p3_r     <= '0;
      warn_r   <= '0;
      odl_r    <= '0;
      base_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_TIER_ONE_BOUND:  t1_lim_r <= cfg_lim;
        REG_TIER_TWO_BOUND:  t2_lim_r <= cfg_lim;
        REG_PRICE_ONE:       p1_r     <= cfg_wdata[PRICE_W-1:0];
        REG_PRICE_TWO:       p2_r     <= cfg_wdata[PRICE_W-1:0];
        REG_PRICE_THREE:     p3_r     <= cfg_wdata[PRICE_W-1:0];
        REG_WARN_MARGIN:     warn_r   <= cfg_wdata[MONEY_W-1:0];
        REG_OVERDRAFT_LIMIT: odl_r    <= cfg_wdata[MONEY_W-1:0];
        REG_CYCLE_BASE:      base_r   <= cfg_wdata[MONEY_W-1:0];
        default: ;
      endcase
    end
  end

  assign gas_inc = gas_r + MONEY_W'(1);
  assign usage   = gas_inc - base_r;

  always_comb begin
    priority if (usage <= {{(MONEY_W-LIMIT_W){1'b0}}, t1_lim_r}) begin
      price = p1_r;
    end else if (usage <= {{(MONEY_W-LIMIT_W){1'b0}}, t2_lim_r}) begin
      price = p2_r;
    end else begin
      price = p3_r;
    end
  end

  assign price_ext = {{(MONEY_W-PRICE_W){1'b0}}, price};
  assign bal_sub   = bal_r - price_ext;
  assign owed_sum  = {1'b0, owed_r} + {1'b0, price_ext};
  assign cover_sum = {1'b0, bal_sub} + {1'b0, odl_r};

  always_comb begin
    gas_nxt   = gas_r;
    bal_nxt   = bal_r;
    owed_nxt  = owed_r;
    spent_nxt = spent_r;
    armed_nxt = armed_r;
    res_nxt.counted     = 1'b0;
    res_nxt.unit_price  = '0;
    res_nxt.low_alert   = 1'b0;
    res_nxt.close_valve = 1'b0;
    if (command_t'(in_ch.command) == CMD_LOAD) begin
      bal_nxt  = in_ch.amount;
      owed_nxt = '0;
    end else if (in_ch.pin_low) begin
      res_nxt.counted    = 1'b1;
      res_nxt.unit_price = price;
      gas_nxt            = gas_inc;
      spent_nxt          = spent_r + price_ext;
      if (bal_r >= price_ext) begin
        bal_nxt = bal_sub;
        if (bal_sub < warn_r && armed_r) begin
          res_nxt.low_alert = 1'b1;
          armed_nxt         = 1'b0;
        end else if (bal_sub >= warn_r && !armed_r) begin
          armed_nxt = 1'b1;
        end
        res_nxt.close_valve = cover_sum < {1'b0, price_ext};
      end else begin
        if (bal_r == '0) begin
          // saturate the overdraft
          owed_nxt = owed_sum[MONEY_W] ? {MONEY_W{1'b1}} : owed_sum[MONEY_W-1:0];
        end else begin
          owed_nxt = price_ext - bal_r;
          bal_nxt  = '0;
        end
        res_nxt.close_valve = owed_nxt >= odl_r;
      end
    end
    res_nxt.balance    = bal_nxt;
    res_nxt.overdraft  = owed_nxt;
    res_nxt.money_used = spent_nxt;
    res_nxt.gas_total  = gas_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gas_r       <= '0;
      bal_r       <= '0;
      owed_r      <= '0;
      spent_r     <= '0;
      armed_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        gas_r   <= gas_nxt;
        bal_r   <= bal_nxt;
        owed_r  <= owed_nxt;
        spent_r <= spent_nxt;
        armed_r <= armed_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.counted     = res_r.counted;
  assign out_ch.unit_price  = res_r.unit_price;
  assign out_ch.balance     = res_r.balance;
  assign out_ch.overdraft   = res_r.overdraft;
  assign out_ch.money_used  = res_r.money_used;
  assign out_ch.gas_total   = res_r.gas_total;
  assign out_ch.low_alert   = res_r.low_alert;
  assign out_ch.close_valve = res_r.close_valve;

  // balance and overdraft are never both outstanding
  a_bal_owed_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (bal_r == '0) || (owed_r == '0))
    else $error("balance and overdraft both nonzero");

  a_uncounted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.counted |->
      !res_r.low_alert && !res_r.close_valve && (res_r.unit_price == '0))
    else $error("uncounted item carries a charge or flag");

  a_alert_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res_nxt.low_alert |=> !armed_r)
    else $error("alert fired but remained armed");

  a_load_clears_owed: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (command_t'(in_ch.command) == CMD_LOAD) |=>
      (owed_r == '0) && (res_r.overdraft == '0))
    else $error("load left an overdraft");

endmodule
`default_nettype wire
